// ===== rtl/ssp_frame_receive_checker_assert.svh =====
// Assertion macros used by the frame receive checker output skid stage.
`ifndef SSP_FRAME_RECEIVE_CHECKER_ASSERT_SVH
`define SSP_FRAME_RECEIVE_CHECKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFRC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFRC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the frame receive checker.
package sfrc_pkg;

    // Frame phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_ADDR = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRCL = 3'd4;
    localparam logic [2:0] PH_CRCH = 3'd5;

    // Verdict status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PROTO = 2'd1;
    localparam logic [1:0] ST_ID    = 2'd2;
    localparam logic [1:0] ST_CRC   = 2'd3;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Input actions
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    // Register indexes
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_CRC_POLY       = 2'd1;
    localparam logic [1:0] REG_FRAME_PREFIX   = 2'd2;
    localparam logic [1:0] REG_MIN_FRAME_SIZE = 2'd3;

    // Register reset values
    localparam logic [6:0]  RST_DEVICE_ADDRESS = 7'd0;
    localparam logic [15:0] RST_CRC_POLY       = 16'h8005;
    localparam logic [7:0]  RST_FRAME_PREFIX   = 8'h7F;
    localparam logic [8:0]  RST_MIN_FRAME_SIZE = 9'd6;

    // CRC and framing constants
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_MSB        = 16'h8000;
    localparam logic [8:0]  FRAME_OVERHEAD = 9'd5;

    localparam int PADDR_W = 4;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [15:0] crc_poly;
        logic [7:0]  frame_prefix;
        logic [8:0]  min_frame_size;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic [1:0] status;
        logic [7:0] payload_length;
        logic       last;
    } res_t;

endpackage

// ===== rtl/sfrc_crc_byte.sv =====
`timescale 1ns / 1ps
// Byte-wide MSB-first CRC-16 update with a programmable polynomial.
module sfrc_crc_byte
    import sfrc_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    input  logic [15:0] poly,
    output logic [15:0] crc_out
);

    // Unroll the eight bit steps of one byte
    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_MSB) != 16'h0000)
                c = {c[14:0], 1'b0} ^ poly;
            else
                c = {c[14:0], 1'b0};
        end
        crc_out = c;
    end

endmodule

// ===== rtl/sfrc_cfg_regs.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers of the frame receive checker.
module sfrc_cfg_regs
    import sfrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [6:0]  device_address_reg;
    logic [15:0] crc_poly_reg;
    logic [7:0]  frame_prefix_reg;
    logic [8:0]  min_frame_size_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // Write the addressed register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= RST_DEVICE_ADDRESS;
            crc_poly_reg       <= RST_CRC_POLY;
            frame_prefix_reg   <= RST_FRAME_PREFIX;
            min_frame_size_reg <= RST_MIN_FRAME_SIZE;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DEVICE_ADDRESS: device_address_reg <= pwdata[6:0];
                REG_CRC_POLY:       crc_poly_reg       <= pwdata[15:0];
                REG_FRAME_PREFIX:   frame_prefix_reg   <= pwdata[7:0];
                REG_MIN_FRAME_SIZE: min_frame_size_reg <= pwdata[8:0];
            endcase
        end
    end

    // Return the addressed register on read
    always_comb
    begin
        unique case (reg_idx)
            REG_DEVICE_ADDRESS: prdata = {25'd0, device_address_reg};
            REG_CRC_POLY:       prdata = {16'd0, crc_poly_reg};
            REG_FRAME_PREFIX:   prdata = {24'd0, frame_prefix_reg};
            REG_MIN_FRAME_SIZE: prdata = {23'd0, min_frame_size_reg};
        endcase
    end

    assign cfg.device_address = device_address_reg;
    assign cfg.crc_poly       = crc_poly_reg;
    assign cfg.frame_prefix   = frame_prefix_reg;
    assign cfg.min_frame_size = min_frame_size_reg;

endmodule

// ===== rtl/sfrc_frame_fsm.sv =====
`timescale 1ns / 1ps
// Frame parser: destuffing, id check, CRC accumulation and verdicts.
module sfrc_frame_fsm
    import sfrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic       action,
    input  logic [7:0] rx_byte,
    input  logic       expect_seq,
    output logic       res_valid,
    output res_t       res
);

    logic [2:0]  phase_reg, phase_next;
    logic        stuff_pending_reg, stuff_pending_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic        id_bad_reg, id_bad_next;
    logic [7:0]  crc_low_byte_reg, crc_low_byte_next;

    logic        hit;
    logic        lone;
    logic [15:0] crc_seed;
    logic [15:0] crc_upd;
    logic        id_mismatch;
    logic [7:0]  left_dec;
    logic        too_short;

    assign hit  = (rx_byte == cfg.frame_prefix);
    assign lone = (action == ACT_BYTE) && (phase_reg != PH_IDLE)
                  && stuff_pending_reg && !hit;
    // A lone prefix restarts the CRC for the new frame's address byte
    assign crc_seed    = lone ? CRC_INIT : running_crc_reg;
    assign id_mismatch = (rx_byte[6:0] != cfg.device_address) || (rx_byte[7] != expect_seq);
    assign left_dec    = bytes_left_reg - 8'd1;
    assign too_short   = ({1'b0, frame_length_reg} + FRAME_OVERHEAD) < cfg.min_frame_size;

    sfrc_crc_byte u_crc (
        .crc_in  (crc_seed),
        .data    (rx_byte),
        .poly    (cfg.crc_poly),
        .crc_out (crc_upd)
    );

    // Decode one request against the frame state
    always_comb
    begin
        phase_next         = phase_reg;
        stuff_pending_next = stuff_pending_reg;
        running_crc_next   = running_crc_reg;
        frame_length_next  = frame_length_reg;
        bytes_left_next    = bytes_left_reg;
        id_bad_next        = id_bad_reg;
        crc_low_byte_next  = crc_low_byte_reg;
        res_valid          = 1'b0;
        res.kind           = KIND_VERDICT;
        res.payload        = 8'd0;
        res.status         = ST_PROTO;
        res.payload_length = frame_length_reg;
        res.last           = 1'b1;

        if (accept)
        begin
            priority if (action == ACT_TIMEOUT)
            begin
                // Abort an open frame, ignore while idle
                if (phase_reg != PH_IDLE)
                begin
                    res_valid          = 1'b1;
                    phase_next         = PH_IDLE;
                    stuff_pending_next = 1'b0;
                end
            end
            else if (phase_reg == PH_IDLE)
            begin
                // Hunt for the prefix
                if (hit)
                begin
                    phase_next         = PH_ADDR;
                    stuff_pending_next = 1'b0;
                    running_crc_next   = CRC_INIT;
                    frame_length_next  = 8'd0;
                    bytes_left_next    = 8'd0;
                    id_bad_next        = 1'b0;
                    crc_low_byte_next  = 8'd0;
                end
            end
            else if (lone)
            begin
                // Drop the frame; the prefix opens a new one, this byte is its address
                res_valid          = 1'b1;
                phase_next         = PH_LEN;
                stuff_pending_next = 1'b0;
                running_crc_next   = crc_upd;
                frame_length_next  = 8'd0;
                bytes_left_next    = 8'd0;
                id_bad_next        = id_mismatch;
                crc_low_byte_next  = 8'd0;
            end
            else if (!stuff_pending_reg && hit)
            begin
                // Hold the first half of a doubled prefix
                stuff_pending_next = 1'b1;
            end
            else
            begin
                stuff_pending_next = 1'b0;
                unique case (phase_reg)
                    PH_ADDR:
                    begin
                        id_bad_next      = id_mismatch;
                        running_crc_next = crc_upd;
                        phase_next       = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        frame_length_next = rx_byte;
                        bytes_left_next   = rx_byte;
                        running_crc_next  = crc_upd;
                        phase_next        = (rx_byte == 8'd0) ? PH_CRCL : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        running_crc_next = crc_upd;
                        bytes_left_next  = left_dec;
                        if (left_dec == 8'd0)
                            phase_next = PH_CRCL;
                        res_valid   = 1'b1;
                        res.kind    = KIND_PAYLOAD;
                        res.payload = rx_byte;
                        res.status  = ST_OK;
                        res.last    = 1'b0;
                    end
                    PH_CRCL:
                    begin
                        crc_low_byte_next = rx_byte;
                        phase_next        = PH_CRCH;
                    end
                    PH_CRCH:
                    begin
                        res_valid = 1'b1;
                        priority if (too_short)
                            res.status = ST_PROTO;
                        else if (id_bad_reg)
                            res.status = ST_ID;
                        else if ({rx_byte, crc_low_byte_reg} != running_crc_reg)
                            res.status = ST_CRC;
                        else
                            res.status = ST_OK;
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Advance the frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            stuff_pending_reg <= 1'b0;
            running_crc_reg   <= CRC_INIT;
            frame_length_reg  <= 8'd0;
            bytes_left_reg    <= 8'd0;
            id_bad_reg        <= 1'b0;
            crc_low_byte_reg  <= 8'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            stuff_pending_reg <= stuff_pending_next;
            running_crc_reg   <= running_crc_next;
            frame_length_reg  <= frame_length_next;
            bytes_left_reg    <= bytes_left_next;
            id_bad_reg        <= id_bad_next;
            crc_low_byte_reg  <= crc_low_byte_next;
        end
    end

endmodule

// ===== rtl/sfrc_out_skid.sv =====
`timescale 1ns / 1ps
// Result register with a skid stage between the parser and the output channel.
module sfrc_out_skid
    import sfrc_pkg::*;
`include "ssp_frame_receive_checker_assert.svh"
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t res,
    output logic ready,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic advance;

    assign advance   = !out_valid_reg || out_ready;
    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_data_reg;

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Move result data; hold while stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (push)
                out_data_reg <= res;
        end
        else if (push)
        begin
            skid_data_reg <= res;
        end
    end

    `SFRC_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with empty output")
    `SFRC_ASSERT_IMP(a_push_needs_room, push, !skid_valid_reg, "result pushed into full skid")
    `SFRC_ASSERT_NXT(a_stall_fills_skid, out_valid_reg && !out_ready && push, skid_valid_reg,
        "stalled result lost")

endmodule

// ===== rtl/ssp_frame_receive_checker.sv =====
`timescale 1ns / 1ps
// Top level of the frame receive checker.
//
// Input channel (in_valid/in_ready) carries one request per link event: a
// received byte in stuffed form (action 0) or a receive timeout (action 1),
// plus the expected sequence flag used at the address byte.
// Output channel (out_valid/out_ready) carries payload bytes (kind 0) as they
// arrive and one verdict (kind 1, last 1) that closes each frame.
// Registers are written through the APB-style port; pready is tied high.
// A result is registered in the output register when its request is accepted, or
// parked in the skid stage while the receiver stalls. Throughput: one request per
// cycle while in_ready is high, set by the combinational byte-wide CRC update and
// state decode between the state registers and the result register.
// When the receiver stalls, one result is parked in a skid stage and the
// next request is still taken; in_ready drops only while that stage is full.
// Reset returns the parser to prefix hunt, empties the output stages and
// loads the register defaults.
module ssp_frame_receive_checker
    import sfrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [7:0]         rx_byte,
    input  logic               expect_seq,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [7:0]         payload,
    output logic [1:0]         status,
    output logic [7:0]         payload_length,
    output logic               last
);

    cfg_t cfg;
    res_t res;
    res_t out_res;
    logic res_valid;
    logic accept;

    assign accept = in_valid && in_ready;

    sfrc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfrc_frame_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .accept     (accept),
        .action     (action),
        .rx_byte    (rx_byte),
        .expect_seq (expect_seq),
        .res_valid  (res_valid),
        .res        (res)
    );

    sfrc_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .res       (res),
        .ready     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind           = out_res.kind;
    assign payload        = out_res.payload;
    assign status         = out_res.status;
    assign payload_length = out_res.payload_length;
    assign last           = out_res.last;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the frame receive checker: frames, errors, stuffing and stalls.
module testbench;
    import sfrc_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int FULL_FRAME = 1 << 20;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               action = ACT_BYTE;
    logic [7:0]         rx_byte = 8'h00;
    logic               expect_seq = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               kind;
    logic [7:0]         payload;
    logic [1:0]         status;
    logic [7:0]         payload_length;
    logic               last;

    // Register mirror and parser shadow state
    cfg_t       cfg_mirror;
    logic [2:0] rx_phase;
    logic       prefix_pending;
    logic [15:0] crc_acc;
    logic [7:0] length_byte;
    logic [7:0] bytes_remaining;
    logic       id_mismatch;
    logic [7:0] crc_low;

    res_t expected_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;
    int mismatches = 0;
    int requests_seen = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int verdict_count[4] = '{0, 0, 0, 0};

    ssp_frame_receive_checker u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .rx_byte        (rx_byte),
        .expect_seq     (expect_seq),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload        (payload),
        .status         (status),
        .payload_length (payload_length),
        .last           (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH @%0t: %s", $time, msg);
    endfunction

    // MSB-first CRC-16 over one byte with the configured polynomial
    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        int          i;
        c = crc ^ {b, 8'h00};
        for (i = 0; i < 8; i++)
        begin
            if ((c & CRC_MSB) != 0)
                c = (c << 1) ^ cfg_mirror.crc_poly;
            else
                c = c << 1;
        end
        return c;
    endfunction

    function automatic void push_result(logic k, logic [7:0] data, logic [1:0] st);
        res_t r;
        r.kind = k;
        r.payload = data;
        r.status = st;
        r.payload_length = length_byte;
        r.last = k;
        expected_results.push_back(r);
        if (k == KIND_VERDICT)
            verdict_count[st]++;
    endfunction

    function automatic void open_frame();
        rx_phase = PH_ADDR;
        prefix_pending = 1'b0;
        crc_acc = CRC_INIT;
        length_byte = 8'h00;
        bytes_remaining = 8'h00;
        id_mismatch = 1'b0;
        crc_low = 8'h00;
    endfunction

    // Advance the frame parser by one destuffed byte
    function automatic void take_frame_byte(logic [7:0] b, logic seq);
        logic [1:0] st;
        case (rx_phase)
            PH_ADDR:
            begin
                id_mismatch = (b[6:0] != cfg_mirror.device_address) || (b[7] != seq);
                crc_acc = crc16_step(crc_acc, b);
                rx_phase = PH_LEN;
            end
            PH_LEN:
            begin
                length_byte = b;
                bytes_remaining = b;
                crc_acc = crc16_step(crc_acc, b);
                rx_phase = (b == 8'h00) ? PH_CRCL : PH_DATA;
            end
            PH_DATA:
            begin
                crc_acc = crc16_step(crc_acc, b);
                bytes_remaining = bytes_remaining - 8'd1;
                if (bytes_remaining == 8'h00)
                    rx_phase = PH_CRCL;
                push_result(KIND_PAYLOAD, b, ST_OK);
            end
            PH_CRCL:
            begin
                crc_low = b;
                rx_phase = PH_CRCH;
            end
            PH_CRCH:
            begin
                if ({1'b0, length_byte} + FRAME_OVERHEAD < cfg_mirror.min_frame_size)
                    st = ST_PROTO;
                else if (id_mismatch)
                    st = ST_ID;
                else if ({b, crc_low} != crc_acc)
                    st = ST_CRC;
                else
                    st = ST_OK;
                push_result(KIND_VERDICT, 8'h00, st);
                rx_phase = PH_IDLE;
                prefix_pending = 1'b0;
            end
            default:
                rx_phase = PH_IDLE;
        endcase
    endfunction

    // Work out the results of one accepted request
    function automatic void predict_request(logic act, logic [7:0] b, logic seq);
        if (act == ACT_TIMEOUT)
        begin
            if (rx_phase != PH_IDLE)
            begin
                push_result(KIND_VERDICT, 8'h00, ST_PROTO);
                rx_phase = PH_IDLE;
                prefix_pending = 1'b0;
            end
        end
        else if (rx_phase == PH_IDLE)
        begin
            if (b == cfg_mirror.frame_prefix)
                open_frame();
        end
        else if (prefix_pending)
        begin
            prefix_pending = 1'b0;
            if (b == cfg_mirror.frame_prefix)
                take_frame_byte(b, seq);
            else
            begin
                // Lone prefix: abort, it opens a new frame and b is its address
                push_result(KIND_VERDICT, 8'h00, ST_PROTO);
                open_frame();
                take_frame_byte(b, seq);
            end
        end
        else if (b == cfg_mirror.frame_prefix)
            prefix_pending = 1'b1;
        else
            take_frame_byte(b, seq);
    endfunction

    // Predict on accepted requests, check accepted results
    always @(posedge clk)
    begin : scoreboard
        res_t want;
        res_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_request(action, rx_byte, expect_seq);
                requests_seen++;
            end
            if (out_valid && out_ready)
            begin
                got.kind = kind;
                got.payload = payload;
                got.status = status;
                got.payload_length = payload_length;
                got.last = last;
                results_seen++;
                if (expected_results.size() == 0)
                    note_mismatch($sformatf("unexpected result kind %0d payload %02h status %0d",
                                            got.kind, got.payload, got.status));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.payload !== want.payload ||
                        got.status !== want.status ||
                        got.payload_length !== want.payload_length || got.last !== want.last)
                        note_mismatch($sformatf(
                            "expected kind %0d payload %02h status %0d length %0d last %0d, %s",
                            want.kind, want.payload, want.status, want.payload_length,
                            want.last,
                            $sformatf("got kind %0d payload %02h status %0d length %0d last %0d",
                                      got.kind, got.payload, got.status, got.payload_length,
                                      got.last)));
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one request, with a random gap first; valid stays high on return
    task automatic send_request(input logic act, input logic [7:0] b, input logic seq);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        action <= act;
        rx_byte <= b;
        expect_seq <= seq;
        do @(posedge clk); while (!in_ready);
    endtask

    // Send one frame byte, doubled when it equals the prefix
    task automatic send_link_byte(input logic [7:0] b, input logic seq);
        send_request(ACT_BYTE, b, seq);
        if (b == cfg_mirror.frame_prefix)
            send_request(ACT_BYTE, b, seq);
    endtask

    function automatic logic [7:0] pick_payload_byte();
        int r;
        r = $urandom_range(11);
        if (r < 2)
            return cfg_mirror.frame_prefix;
        else if (r == 2)
            return 8'h00;
        else if (r == 3)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return 255;
        else if (r < 8)
            return $urandom_range(60, 9);
        return $urandom_range(8);
    endfunction

    // Send prefix and the first cut body bytes of a frame; fill < 0 picks random payload
    task automatic send_frame(input logic [7:0] addr_byte, input logic seq, input int len,
                              input int fill, input logic crc_bad, input int cut);
        logic [7:0]  body[$];
        logic [15:0] crc;
        int          i;
        body.push_back(addr_byte);
        body.push_back(8'(len));
        for (i = 0; i < len; i++)
            body.push_back((fill < 0) ? pick_payload_byte() : 8'(fill));
        crc = CRC_INIT;
        for (i = 0; i < body.size(); i++)
            crc = crc16_step(crc, body[i]);
        if (crc_bad)
            crc = crc ^ 16'($urandom_range(65535, 1));
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        send_request(ACT_BYTE, cfg_mirror.frame_prefix, 1'($urandom_range(1)));
        for (i = 0; i < body.size() && i < cut; i++)
            send_link_byte(body[i], (i == 0) ? seq : 1'($urandom_range(1)));
    endtask

    // Drop valid, wait for every expected result, then let the pipe settle
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [1:0] idx, output logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        value = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] mirror_value(logic [1:0] idx);
        case (idx)
            REG_DEVICE_ADDRESS: return {25'd0, cfg_mirror.device_address};
            REG_CRC_POLY:       return {16'd0, cfg_mirror.crc_poly};
            REG_FRAME_PREFIX:   return {24'd0, cfg_mirror.frame_prefix};
            default:            return {23'd0, cfg_mirror.min_frame_size};
        endcase
    endfunction

    // Read back every register and compare with the mirror
    task automatic check_registers();
        logic [31:0] value;
        int          i;
        for (i = 0; i < 4; i++)
        begin
            apb_read(2'(i), value);
            if (value !== mirror_value(2'(i)))
                note_mismatch($sformatf("register %0d reads %08h, expected %08h",
                                        i, value, mirror_value(2'(i))));
        end
    endtask

    task automatic apply_config(input logic [6:0] dev, input logic [15:0] poly,
                                input logic [7:0] prefix, input logic [8:0] min_size);
        wait_until_idle();
        apb_write(REG_DEVICE_ADDRESS, {25'd0, dev});
        apb_write(REG_CRC_POLY, {16'd0, poly});
        apb_write(REG_FRAME_PREFIX, {24'd0, prefix});
        apb_write(REG_MIN_FRAME_SIZE, {23'd0, min_size});
        cfg_mirror.device_address = dev;
        cfg_mirror.crc_poly = poly;
        cfg_mirror.frame_prefix = prefix;
        cfg_mirror.min_frame_size = min_size;
        check_registers();
    endtask

    task automatic test_register_defaults();
        check_registers();
    endtask

    // Bytes and timeouts outside a frame give nothing
    task automatic test_idle_bytes();
        send_request(ACT_BYTE, 8'h00, 1'b0);
        send_request(ACT_BYTE, 8'hFF, 1'b1);
        send_request(ACT_TIMEOUT, 8'hFF, 1'b1);
    endtask

    // Sequence flag mismatch on a frame whose payload is a stuffed prefix
    task automatic test_sequence_mismatch_and_stuffing();
        send_frame({1'b1, cfg_mirror.device_address}, 1'b0, 1,
                   int'(cfg_mirror.frame_prefix), 1'b0, FULL_FRAME);
    endtask

    // Zero length frame falls below the minimum size
    task automatic test_short_frame();
        send_frame({1'b0, cfg_mirror.device_address}, 1'b0, 0, -1, 1'b0, FULL_FRAME);
    endtask

    // Lone prefix restarts the frame; timeout while a prefix is pending aborts it
    task automatic test_lone_prefix_and_timeout();
        send_request(ACT_BYTE, cfg_mirror.frame_prefix, 1'b0);
        send_request(ACT_BYTE, 8'h00, 1'b0);
        send_request(ACT_BYTE, cfg_mirror.frame_prefix, 1'b1);
        send_request(ACT_BYTE, 8'h00, 1'b0);
        send_request(ACT_BYTE, 8'h03, 1'b1);
        send_request(ACT_BYTE, cfg_mirror.frame_prefix, 1'b0);
        send_request(ACT_TIMEOUT, 8'h00, 1'b0);
    endtask

    task automatic test_crc_error();
        send_frame({1'b0, cfg_mirror.device_address}, 1'b0, 1, 255, 1'b1, FULL_FRAME);
    endtask

    // Mostly well-formed frames with random content, plus errors and noise
    task automatic test_random_traffic(input logic [6:0] dev, input logic [15:0] poly,
                                       input logic [7:0] prefix, input logic [8:0] min_size,
                                       input int count);
        int         start;
        int         r;
        int         len;
        logic       seq;
        logic [6:0] dev_now;
        apply_config(dev, poly, prefix, min_size);
        start = requests_seen;
        while (requests_seen - start < count)
        begin
            r = $urandom_range(99);
            len = pick_length();
            seq = 1'($urandom_range(1));
            dev_now = cfg_mirror.device_address;
            if (r < 55)
                send_frame({seq, dev_now}, seq, len, -1, 1'b0, FULL_FRAME);
            else if (r < 65)
            begin
                if ($urandom_range(1) == 0)
                    send_frame({~seq, dev_now}, seq, len, -1, 1'b0, FULL_FRAME);
                else
                    send_frame({seq, dev_now ^ 7'($urandom_range(127, 1))}, seq, len, -1,
                               1'b0, FULL_FRAME);
            end
            else if (r < 75)
                send_frame({seq, dev_now}, seq, len, -1, 1'b1, FULL_FRAME);
            else if (r < 83)
            begin
                // cut the frame short with a timeout
                send_frame({seq, dev_now}, seq, len, -1, 1'b0, $urandom_range(len + 3));
                send_request(ACT_TIMEOUT, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            else if (r < 90)
            begin
                // broken frame, then a full one whose prefix stands alone
                send_frame({seq, dev_now}, seq, len, -1, 1'b0, $urandom_range(len + 3, 1));
                send_frame({seq, dev_now}, seq, pick_length(), -1, 1'b0, FULL_FRAME);
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    send_request(ACT_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
                if ($urandom_range(1) == 0)
                    send_request(ACT_TIMEOUT, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
    endtask

    // Hold the receiver off while a long frame keeps arriving
    task automatic test_receiver_hold_off();
        wait_until_idle();
        hold_off_cycles = 300;
        send_frame({1'b0, cfg_mirror.device_address}, 1'b0, 24, -1, 1'b0, FULL_FRAME);
        send_frame({1'b1, cfg_mirror.device_address}, 1'b1, 6, -1, 1'b0, FULL_FRAME);
    endtask

    initial
    begin
        cfg_mirror.device_address = RST_DEVICE_ADDRESS;
        cfg_mirror.crc_poly = RST_CRC_POLY;
        cfg_mirror.frame_prefix = RST_FRAME_PREFIX;
        cfg_mirror.min_frame_size = RST_MIN_FRAME_SIZE;
        rx_phase = PH_IDLE;
        prefix_pending = 1'b0;
        crc_acc = CRC_INIT;
        length_byte = 8'h00;
        bytes_remaining = 8'h00;
        id_mismatch = 1'b0;
        crc_low = 8'h00;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();

        send_idle_pct = 21;
        recv_idle_pct = 56;
        test_idle_bytes();
        test_sequence_mismatch_and_stuffing();
        test_short_frame();
        test_lone_prefix_and_timeout();
        test_crc_error();
        test_random_traffic(7'd127, 16'h8005, 8'h7E, 9'd5, 560);
        test_receiver_hold_off();

        send_idle_pct = 56;
        recv_idle_pct = 21;
        test_random_traffic(7'd0, 16'hFFFF, 8'h00, 9'd8, 560);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(7'($urandom_range(127)), 16'h1021, 8'hFF, 9'd6, 420);
        test_random_traffic(7'($urandom_range(127)), 16'h0000, 8'($urandom_range(255)),
                            9'd260, 150);
        wait_until_idle();

        $display("Covered %0d link requests and %0d results over five register settings",
                 requests_seen, results_seen);
        $display("Frame verdicts: ok %0d, protocol %0d, id %0d, crc %0d",
                 verdict_count[ST_OK], verdict_count[ST_PROTO], verdict_count[ST_ID],
                 verdict_count[ST_CRC]);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
